@@ src/sfs_pkg.sv @@
package sfs_pkg;

    localparam int SEARCH_WINDOW   = 512;
    localparam int TEXT_MIN_SIZE   = 160;
    localparam int FIXED_MIN_SIZE  = 15;
    localparam int FIXED_LEN_INDEX = 8;
    localparam int STR_MIN_SIZE    = 40;
    localparam int POS_MAX         = 1023;
    localparam int SKEL_KEY_LEN    = 10;
    localparam int VER_KEY_LEN     = 7;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        FMT_NONE   = 2'd0,
        FMT_TEXT   = 2'd1,
        FMT_FIXED  = 2'd2,
        FMT_STRING = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        QP_WAIT   = 2'd0,
        QP_IN     = 2'd1,
        QP_CLOSED = 2'd2
    } qphase_t;

    // One byte as the checkers see it
    typedef struct packed {
        logic        en;        // byte taken this cycle
        logic        last;      // final byte of the file
        logic [7:0]  data;
        logic [9:0]  idx;       // byte index, saturated
        logic        have_idx;  // index still valid (below saturation)
        logic [10:0] count;     // bytes seen including this one
    } step_t;

    typedef struct packed {
        logic       hit;
        logic [8:0] offset;
        logic [8:0] length;
    } verdict_t;

    function automatic logic is_digit_or_dot(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || c == CH_DOT;
    endfunction

    function automatic logic is_hash_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == CH_PLUS || c == CH_SLASH;
    endfunction

    // "skeleton" with its quotes
    function automatic logic [7:0] skel_key_char(input logic [3:0] p);
        logic [7:0] ch;
        case (p)
            4'd0:    ch = CH_QUOTE;
            4'd1:    ch = 8'h73;
            4'd2:    ch = 8'h6B;
            4'd3:    ch = 8'h65;
            4'd4:    ch = 8'h6C;
            4'd5:    ch = 8'h65;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h6F;
            4'd8:    ch = 8'h6E;
            4'd9:    ch = CH_QUOTE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "spine" with its quotes
    function automatic logic [7:0] ver_key_char(input logic [2:0] p);
        logic [7:0] ch;
        case (p)
            3'd0:    ch = CH_QUOTE;
            3'd1:    ch = 8'h73;
            3'd2:    ch = 8'h70;
            3'd3:    ch = 8'h69;
            3'd4:    ch = 8'h6E;
            3'd5:    ch = 8'h65;
            3'd6:    ch = CH_QUOTE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ src/sfs_text_check.sv @@
module sfs_text_check (
    input  logic             aclk,
    input  logic             aresetn,
    input  sfs_pkg::step_t   st,
    output sfs_pkg::verdict_t verdict
);

    logic [3:0]       skel_prog_reg, skel_prog_upd, skel_prog_next;
    logic             skel_seen_reg, skel_seen_upd, skel_seen_next;
    logic [2:0]       ver_prog_reg, ver_prog_upd, ver_prog_next;
    logic             ver_seen_reg, ver_seen_upd, ver_seen_next;
    sfs_pkg::qphase_t phase_reg, phase_upd, phase_next;
    logic [8:0]       start_reg, start_upd, start_next;
    logic [8:0]       len_reg, len_upd, len_next;
    logic             ok_reg, ok_upd, ok_next;
    logic             window;
    logic             clear;
    logic             quote;

    assign window = st.en && st.have_idx && ({1'b0, st.idx} < 11'(sfs_pkg::SEARCH_WINDOW));
    assign clear  = st.en && st.last;
    assign quote  = (st.data == sfs_pkg::CH_QUOTE);

    // key matchers
    always_comb begin
        skel_prog_upd = skel_prog_reg;
        skel_seen_upd = skel_seen_reg;
        ver_prog_upd  = ver_prog_reg;
        ver_seen_upd  = ver_seen_reg;
        if (window && !skel_seen_reg) begin
            if (st.data == sfs_pkg::skel_key_char(skel_prog_reg)) begin
                skel_prog_upd = skel_prog_reg + 4'd1;
            end else begin
                skel_prog_upd = quote ? 4'd1 : 4'd0;
            end
            skel_seen_upd = (skel_prog_upd >= 4'(sfs_pkg::SKEL_KEY_LEN));
        end
        if (window && !ver_seen_reg) begin
            if (st.data == sfs_pkg::ver_key_char(ver_prog_reg)) begin
                ver_prog_upd = ver_prog_reg + 3'd1;
            end else begin
                ver_prog_upd = quote ? 3'd1 : 3'd0;
            end
            ver_seen_upd = (ver_prog_upd >= 3'(sfs_pkg::VER_KEY_LEN));
        end
    end

    // quote phase: next state
    always_comb begin
        phase_upd = phase_reg;
        if (window && ver_seen_reg && quote) begin
            case (phase_reg)
                sfs_pkg::QP_WAIT: phase_upd = sfs_pkg::QP_IN;
                sfs_pkg::QP_IN:   phase_upd = sfs_pkg::QP_CLOSED;
                default:          phase_upd = phase_reg;
            endcase
        end
    end

    // quote phase: version capture
    always_comb begin
        start_upd = start_reg;
        len_upd   = len_reg;
        ok_upd    = ok_reg;
        if (window && ver_seen_reg) begin
            case (phase_reg)
                sfs_pkg::QP_WAIT: begin
                    if (quote) begin
                        start_upd = 9'(st.idx + 10'd1);
                        len_upd   = 9'd0;
                    end
                end
                sfs_pkg::QP_IN: begin
                    if (!quote) begin
                        len_upd = len_reg + 9'd1;
                        if (!sfs_pkg::is_digit_or_dot(st.data)) ok_upd = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (clear) begin
            skel_prog_next = '0;
            skel_seen_next = 1'b0;
            ver_prog_next  = '0;
            ver_seen_next  = 1'b0;
            phase_next     = sfs_pkg::QP_WAIT;
            start_next     = '0;
            len_next       = '0;
            ok_next        = 1'b1;
        end else begin
            skel_prog_next = skel_prog_upd;
            skel_seen_next = skel_seen_upd;
            ver_prog_next  = ver_prog_upd;
            ver_seen_next  = ver_seen_upd;
            phase_next     = phase_upd;
            start_next     = start_upd;
            len_next       = len_upd;
            ok_next        = ok_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skel_prog_reg <= '0;
            skel_seen_reg <= 1'b0;
            ver_prog_reg  <= '0;
            ver_seen_reg  <= 1'b0;
            phase_reg     <= sfs_pkg::QP_WAIT;
            start_reg     <= '0;
            len_reg       <= '0;
            ok_reg        <= 1'b1;
        end else begin
            skel_prog_reg <= skel_prog_next;
            skel_seen_reg <= skel_seen_next;
            ver_prog_reg  <= ver_prog_next;
            ver_seen_reg  <= ver_seen_next;
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            len_reg       <= len_next;
            ok_reg        <= ok_next;
        end
    end

    assign verdict.hit    = (st.count >= 11'(sfs_pkg::TEXT_MIN_SIZE)) && skel_seen_upd &&
                            ver_seen_upd && (phase_upd == sfs_pkg::QP_CLOSED) && ok_upd;
    assign verdict.offset = start_upd;
    assign verdict.length = len_upd;

endmodule

@@ src/sfs_bin_check.sv @@
module sfs_bin_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  sfs_pkg::step_t    st,
    output sfs_pkg::verdict_t fixed_verdict,
    output sfs_pkg::verdict_t str_verdict
);

    logic [7:0] flen_reg, flen_upd, flen_next;
    logic       fok_reg, fok_upd, fok_next;
    logic [7:0] hlen_reg, hlen_upd, hlen_next;
    logic       hok_reg, hok_upd, hok_next;
    logic [7:0] svlen_reg, svlen_upd, svlen_next;
    logic [8:0] svstart_reg, svstart_upd, svstart_next;
    logic       svok_reg, svok_upd, svok_next;
    logic       act;
    logic       clear;
    logic [10:0] idx_w;

    assign act   = st.en && st.have_idx;
    assign clear = st.en && st.last;
    assign idx_w = {1'b0, st.idx};

    // fixed-length version after the length byte
    always_comb begin
        flen_upd = flen_reg;
        fok_upd  = fok_reg;
        if (act) begin
            if (st.idx == 10'(sfs_pkg::FIXED_LEN_INDEX)) begin
                flen_upd = st.data;
                if (st.data == 8'd0) fok_upd = 1'b0;
            end else if (st.idx > 10'(sfs_pkg::FIXED_LEN_INDEX) && flen_reg != 8'd0 &&
                         idx_w < 11'(sfs_pkg::FIXED_LEN_INDEX) + {3'b0, flen_reg}) begin
                if (!sfs_pkg::is_digit_or_dot(st.data)) fok_upd = 1'b0;
            end
        end
    end

    // length-prefixed hash, then length-prefixed version
    always_comb begin
        hlen_upd    = hlen_reg;
        hok_upd     = hok_reg;
        svlen_upd   = svlen_reg;
        svstart_upd = svstart_reg;
        svok_upd    = svok_reg;
        if (act) begin
            if (st.idx == 10'd0) begin
                hlen_upd = st.data;
                if (st.data == 8'd0) hok_upd = 1'b0;
            end else if (hlen_reg != 8'd0) begin
                if (idx_w < {3'b0, hlen_reg}) begin
                    if (!sfs_pkg::is_hash_char(st.data)) hok_upd = 1'b0;
                end else if (idx_w == {3'b0, hlen_reg}) begin
                    svlen_upd   = st.data;
                    svstart_upd = 9'(st.idx + 10'd1);
                    if (st.data == 8'd0) svok_upd = 1'b0;
                end else if (svlen_reg != 8'd0 &&
                             idx_w < {3'b0, hlen_reg} + {3'b0, svlen_reg}) begin
                    if (!sfs_pkg::is_digit_or_dot(st.data)) svok_upd = 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (clear) begin
            flen_next    = '0;
            fok_next     = 1'b1;
            hlen_next    = '0;
            hok_next     = 1'b1;
            svlen_next   = '0;
            svstart_next = '0;
            svok_next    = 1'b1;
        end else begin
            flen_next    = flen_upd;
            fok_next     = fok_upd;
            hlen_next    = hlen_upd;
            hok_next     = hok_upd;
            svlen_next   = svlen_upd;
            svstart_next = svstart_upd;
            svok_next    = svok_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flen_reg    <= '0;
            fok_reg     <= 1'b1;
            hlen_reg    <= '0;
            hok_reg     <= 1'b1;
            svlen_reg   <= '0;
            svstart_reg <= '0;
            svok_reg    <= 1'b1;
        end else begin
            flen_reg    <= flen_next;
            fok_reg     <= fok_next;
            hlen_reg    <= hlen_next;
            hok_reg     <= hok_next;
            svlen_reg   <= svlen_next;
            svstart_reg <= svstart_next;
            svok_reg    <= svok_next;
        end
    end

    assign fixed_verdict.hit    = (st.count >= 11'(sfs_pkg::FIXED_MIN_SIZE)) &&
                                  flen_upd != 8'd0 && fok_upd &&
                                  st.count >= 11'(sfs_pkg::FIXED_LEN_INDEX) + {3'b0, flen_upd};
    assign fixed_verdict.offset = 9'(sfs_pkg::FIXED_LEN_INDEX + 1);
    assign fixed_verdict.length = {1'b0, flen_upd} - 9'd1;

    assign str_verdict.hit    = (st.count >= 11'(sfs_pkg::STR_MIN_SIZE)) &&
                                hlen_upd != 8'd0 && hok_upd &&
                                st.count >= {3'b0, hlen_upd} + 11'd1 &&
                                svlen_upd != 8'd0 && svok_upd &&
                                st.count >= {3'b0, hlen_upd} + {3'b0, svlen_upd};
    assign str_verdict.offset = svstart_upd;
    assign str_verdict.length = {1'b0, svlen_upd} - 9'd1;

endmodule

@@ src/skeleton_file_format_sniffer.sv @@
// Sniffs a file streamed one byte per beat and returns one verdict beat after the beat
// marked tlast: format (none, text, fixed binary, string binary), version offset and
// version length. It takes one byte every cycle unless a last byte waits on a pending
// verdict; each byte waits in the input register, then updates the matcher and counter
// state, and the verdict of a last byte reaches the master side in the next cycle. Only
// the master side stalls it: a pending verdict stalls input only when the next last byte arrives.
module skeleton_file_format_sniffer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [1:0] format_found, [10:2] version_offset,
                                        // [19:11] version_length, [23:20] zero
);

    logic              in_vld_reg, in_vld_next;
    logic [7:0]        in_data_reg;
    logic              in_last_reg;
    logic [9:0]        pos_reg, pos_next;
    logic              pos_over_reg, pos_over_next;
    logic              out_vld_reg, out_vld_next;
    sfs_pkg::fmt_t     out_fmt_reg, out_fmt_next;
    logic [8:0]        out_off_reg, out_off_next;
    logic [8:0]        out_len_reg, out_len_next;
    logic              consume;
    logic              s_fire;
    sfs_pkg::step_t    st;
    sfs_pkg::verdict_t text_v, fixed_v, str_v;

    // a non-last byte always moves on; a last byte needs the result slot
    assign consume       = in_vld_reg && (!in_last_reg || !out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || consume;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign st.en       = consume;
    assign st.last     = in_last_reg;
    assign st.data     = in_data_reg;
    assign st.idx      = pos_reg;
    assign st.have_idx = !pos_over_reg;
    assign st.count    = pos_over_reg ? 11'(sfs_pkg::POS_MAX + 1) : {1'b0, pos_reg} + 11'd1;

    sfs_text_check u_text (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .verdict (text_v)
    );

    sfs_bin_check u_bin (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .st            (st),
        .fixed_verdict (fixed_v),
        .str_verdict   (str_v)
    );

    always_comb begin
        in_vld_next   = s_fire ? 1'b1 : (consume ? 1'b0 : in_vld_reg);
        pos_next      = pos_reg;
        pos_over_next = pos_over_reg;
        if (consume) begin
            if (in_last_reg) begin
                pos_next      = '0;
                pos_over_next = 1'b0;
            end else if (pos_reg < 10'(sfs_pkg::POS_MAX)) begin
                pos_next = pos_reg + 10'd1;
            end else begin
                pos_over_next = 1'b1;
            end
        end
    end

    // pick the first check that passes
    always_comb begin
        out_vld_next = out_vld_reg && !m_axis_tready;
        out_fmt_next = out_fmt_reg;
        out_off_next = out_off_reg;
        out_len_next = out_len_reg;
        if (consume && in_last_reg) begin
            out_vld_next = 1'b1;
            if (text_v.hit) begin
                out_fmt_next = sfs_pkg::FMT_TEXT;
                out_off_next = text_v.offset;
                out_len_next = text_v.length;
            end else if (fixed_v.hit) begin
                out_fmt_next = sfs_pkg::FMT_FIXED;
                out_off_next = fixed_v.offset;
                out_len_next = fixed_v.length;
            end else if (str_v.hit) begin
                out_fmt_next = sfs_pkg::FMT_STRING;
                out_off_next = str_v.offset;
                out_len_next = str_v.length;
            end else begin
                out_fmt_next = sfs_pkg::FMT_NONE;
                out_off_next = '0;
                out_len_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            pos_reg      <= '0;
            pos_over_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            in_vld_reg   <= in_vld_next;
            pos_reg      <= pos_next;
            pos_over_reg <= pos_over_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        out_fmt_reg <= out_fmt_next;
        out_off_reg <= out_off_next;
        out_len_reg <= out_len_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0, out_len_reg, out_off_reg, out_fmt_reg};

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_last_reg) |=> m_axis_tvalid)
        else $error("last byte consumed without a verdict");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_fmt_reg == sfs_pkg::FMT_NONE) |->
        (out_off_reg == 9'd0 && out_len_reg == 9'd0))
        else $error("verdict without format carries version data");

    a_fixed_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_fmt_reg == sfs_pkg::FMT_FIXED) |->
        (out_off_reg == 9'(sfs_pkg::FIXED_LEN_INDEX + 1)))
        else $error("fixed binary verdict with wrong offset");

    a_pos_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_over_reg |-> (pos_reg == 10'(sfs_pkg::POS_MAX)))
        else $error("byte counter overflowed");

    a_file_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_last_reg) |=> (pos_reg == 10'd0 && !pos_over_reg))
        else $error("byte counter not cleared after a file");

endmodule

@@ dv/skeleton_file_format_sniffer_tb.sv @@
module skeleton_file_format_sniffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_PRINTS  = 40;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } file_beat_t;

    typedef struct {
        sfs_pkg::fmt_t fmt;
        logic [8:0]    ver_off;
        logic [8:0]    ver_len;
    } sniff_verdict_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    skeleton_file_format_sniffer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // stimulus and scoreboard storage
    file_beat_t     byte_feed[$];
    sniff_verdict_t verdicts_due[$];
    logic [7:0]     file_buf[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_target    = 0;
    int hold_count     = 0;
    int cycles         = 0;
    int mismatches     = 0;
    int verdicts_seen  = 0;
    int files_sent     = 0;
    int bytes_sent     = 0;
    int fmt_tally[4]   = '{0, 0, 0, 0};

    string skel_word  = "\"skeleton\"";
    string spine_word = "\"spine\"";
    string ver_chars  = "0123456789.";
    string hash_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string filler     = " abcdefghijklmnopqrstuvwxyzABCDEFXYZ0123456789.,:{}[]_-";

    // sniffer state mirror
    logic [9:0]       pos;
    logic             pos_sat;
    logic [3:0]       skel_prog;
    logic             skel_hit;
    logic [2:0]       spine_prog;
    logic             spine_hit;
    sfs_pkg::qphase_t vq_phase;
    logic [8:0]       tver_start;
    logic [8:0]       tver_len;
    logic             tver_good;
    logic [7:0]       fx_len;
    logic             fx_good;
    logic [7:0]       hs_len;
    logic             hs_good;
    logic [7:0]       sv_len;
    logic [8:0]       sv_start;
    logic             sv_good;

    function automatic logic ver_char_ok(input logic [7:0] c);
        return c inside {[8'h30:8'h39], sfs_pkg::CH_DOT};
    endfunction

    function automatic logic hash_char_ok(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                         sfs_pkg::CH_PLUS, sfs_pkg::CH_SLASH};
    endfunction

    function automatic void clear_sniffer();
        pos        = '0;
        pos_sat    = 1'b0;
        skel_prog  = '0;
        skel_hit   = 1'b0;
        spine_prog = '0;
        spine_hit  = 1'b0;
        vq_phase   = sfs_pkg::QP_WAIT;
        tver_start = '0;
        tver_len   = '0;
        tver_good  = 1'b1;
        fx_len     = '0;
        fx_good    = 1'b1;
        hs_len     = '0;
        hs_good    = 1'b1;
        sv_len     = '0;
        sv_start   = '0;
        sv_good    = 1'b1;
    endfunction

    initial clear_sniffer();

    // Advance the mirror by one file byte; queue the verdict on the last one.
    function automatic void sniff_byte(input logic [7:0] c, input logic last);
        logic [9:0]     idx;
        logic           idx_ok;
        int             nbytes;
        sniff_verdict_t v;
        idx    = pos;
        idx_ok = !pos_sat;
        if (idx_ok && idx < sfs_pkg::SEARCH_WINDOW) begin
            if (!skel_hit) begin
                if (c == 8'(skel_word[int'(skel_prog)])) skel_prog = skel_prog + 4'd1;
                else skel_prog = (c == sfs_pkg::CH_QUOTE) ? 4'd1 : 4'd0;
                if (skel_prog >= sfs_pkg::SKEL_KEY_LEN) skel_hit = 1'b1;
            end
            if (!spine_hit) begin
                if (c == 8'(spine_word[int'(spine_prog)])) spine_prog = spine_prog + 3'd1;
                else spine_prog = (c == sfs_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
                if (spine_prog >= sfs_pkg::VER_KEY_LEN) spine_hit = 1'b1;
            end else if (vq_phase == sfs_pkg::QP_WAIT) begin
                if (c == sfs_pkg::CH_QUOTE) begin
                    vq_phase   = sfs_pkg::QP_IN;
                    tver_start = 9'(int'(idx) + 1);
                    tver_len   = '0;
                end
            end else if (vq_phase == sfs_pkg::QP_IN) begin
                if (c == sfs_pkg::CH_QUOTE) begin
                    vq_phase = sfs_pkg::QP_CLOSED;
                end else begin
                    tver_len = tver_len + 9'd1;
                    if (!ver_char_ok(c)) tver_good = 1'b0;
                end
            end
        end
        if (idx_ok) begin
            if (idx == sfs_pkg::FIXED_LEN_INDEX) begin
                fx_len = c;
                if (c == 8'd0) fx_good = 1'b0;
            end else if (idx > sfs_pkg::FIXED_LEN_INDEX && fx_len != 0 &&
                         int'(idx) < sfs_pkg::FIXED_LEN_INDEX + int'(fx_len)) begin
                if (!ver_char_ok(c)) fx_good = 1'b0;
            end
            if (idx == 0) begin
                hs_len = c;
                if (c == 8'd0) hs_good = 1'b0;
            end else if (hs_len != 0) begin
                if (int'(idx) < int'(hs_len)) begin
                    if (!hash_char_ok(c)) hs_good = 1'b0;
                end else if (int'(idx) == int'(hs_len)) begin
                    sv_len   = c;
                    sv_start = 9'(int'(idx) + 1);
                    if (c == 8'd0) sv_good = 1'b0;
                end else if (sv_len != 0 && int'(idx) < int'(hs_len) + int'(sv_len)) begin
                    if (!ver_char_ok(c)) sv_good = 1'b0;
                end
            end
        end
        if (int'(pos) < sfs_pkg::POS_MAX) pos = pos + 10'd1;
        else pos_sat = 1'b1;

        if (last) begin
            nbytes = pos_sat ? sfs_pkg::POS_MAX + 1 : int'(pos);
            v = '{sfs_pkg::FMT_NONE, 9'd0, 9'd0};
            if (nbytes >= sfs_pkg::TEXT_MIN_SIZE && skel_hit && spine_hit &&
                vq_phase == sfs_pkg::QP_CLOSED && tver_good) begin
                v = '{sfs_pkg::FMT_TEXT, tver_start, tver_len};
            end else if (nbytes >= sfs_pkg::FIXED_MIN_SIZE && fx_len != 0 &&
                         nbytes >= sfs_pkg::FIXED_LEN_INDEX + int'(fx_len) && fx_good) begin
                v = '{sfs_pkg::FMT_FIXED, 9'(sfs_pkg::FIXED_LEN_INDEX + 1),
                      9'(int'(fx_len) - 1)};
            end else if (nbytes >= sfs_pkg::STR_MIN_SIZE && hs_len != 0 && hs_good &&
                         nbytes >= int'(hs_len) + 1 && sv_len != 0 &&
                         nbytes >= int'(hs_len) + int'(sv_len) && sv_good) begin
                v = '{sfs_pkg::FMT_STRING, sv_start, 9'(int'(sv_len) - 1)};
            end
            verdicts_due.push_back(v);
            clear_sniffer();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH verdict %0d %s: got %0d expected %0d",
                     verdicts_seen, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Driver, receiver, monitor
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        file_beat_t nb;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nb = byte_feed.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nb.data;
                s_axis_tlast  <= nb.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // hold_target only grows; the long hold-off is counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_count < hold_target) begin
            m_axis_tready <= 1'b0;
            hold_count    <= hold_count + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        sniff_verdict_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("beat with no verdict pending", m_axis_tdata[10:2], 9'd0);
            end else begin
                want = verdicts_due.pop_front();
                fmt_tally[int'(want.fmt)]++;
                if (m_axis_tdata[1:0] !== want.fmt)
                    report_mismatch("format", 9'(m_axis_tdata[1:0]), 9'(want.fmt));
                if (m_axis_tdata[10:2] !== want.ver_off)
                    report_mismatch("version offset", m_axis_tdata[10:2], want.ver_off);
                if (m_axis_tdata[19:11] !== want.ver_len)
                    report_mismatch("version length", m_axis_tdata[19:11], want.ver_len);
                if (m_axis_tdata[23:20] !== 4'h0)
                    report_mismatch("pad bits", 9'(m_axis_tdata[23:20]), 9'd0);
            end
            verdicts_seen++;
        end
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sniff_byte(s_axis_tdata, s_axis_tlast);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycles, verdicts_due.size());
            $display("skeleton_file_format_sniffer verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // File builders
    // ---------------------------------------------------------------
    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) file_buf.push_back(8'(s[i]));
    endtask

    task automatic put_from(input string alphabet, input int n);
        for (int i = 0; i < n; i++)
            file_buf.push_back(8'(alphabet[$urandom_range(alphabet.len() - 1)]));
    endtask

    task automatic put_random(input int n);
        for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom_range(255)));
    endtask

    // digits and dots; spoil one of them with a letter
    task automatic put_version(input int n, input bit spoil);
        int base;
        base = file_buf.size();
        put_from(ver_chars, n);
        if (spoil && n > 0) file_buf[base + $urandom_range(n - 1)] = 8'h76;
    endtask

    task automatic fit_to(input int n, input bit rnd);
        while (file_buf.size() < n) begin
            if (rnd) put_random(1);
            else put_from(filler, 1);
        end
        while (file_buf.size() > n) void'(file_buf.pop_back());
    endtask

    task automatic ship_file();
        file_beat_t b;
        for (int i = 0; i < file_buf.size(); i++) begin
            b.data = file_buf[i];
            b.last = (i == file_buf.size() - 1);
            byte_feed.push_back(b);
        end
        bytes_sent += file_buf.size();
        files_sent++;
        file_buf.delete();
    endtask

    task automatic build_text(input string skel_key, input string spine_key, input int ver_n,
                              input bit spoil, input bit skel_first, input int total);
        file_buf.delete();
        put_str("{");
        put_from(filler, $urandom_range(0, 40));
        if (skel_first) begin
            put_str(skel_key);
            put_str(": \"4.2\", ");
            put_from(filler, $urandom_range(0, 30));
        end
        put_str(spine_key);
        put_str(": \"");
        put_version(ver_n, spoil);
        put_str("\"");
        if (!skel_first) begin
            put_str(", ");
            put_from(filler, $urandom_range(0, 30));
            put_str(skel_key);
            put_str(": {}");
        end
        fit_to(total, 1'b0);
    endtask

    task automatic build_fixed(input int l, input bit spoil, input int total);
        file_buf.delete();
        put_random(sfs_pkg::FIXED_LEN_INDEX);
        file_buf.push_back(8'(l));
        put_version(l > 0 ? l - 1 : 0, spoil);
        fit_to(total, 1'b1);
    endtask

    task automatic build_string(input int h, input int v, input bit spoil_hash,
                                input bit spoil_ver, input int total);
        int base;
        file_buf.delete();
        file_buf.push_back(8'(h));
        base = file_buf.size();
        put_from(hash_chars, h > 0 ? h - 1 : 0);
        // '-' is outside the hash alphabet
        if (spoil_hash && h > 1) file_buf[base + $urandom_range(h - 2)] = 8'h2D;
        file_buf.push_back(8'(v));
        put_version(v > 0 ? v - 1 : 0, spoil_ver);
        fit_to(total, 1'b1);
    endtask

    task automatic ship_random_file();
        int pick;
        int h;
        int v;
        int l;
        pick = $urandom_range(99);
        if (pick < 40) begin
            l = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
            build_fixed(l, $urandom_range(7) == 0, $urandom_range(10, l + 12));
        end else if (pick < 55) begin
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 30);
            v = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
            build_string(h, v, $urandom_range(9) == 0, $urandom_range(9) == 0,
                         $urandom_range(38, 44));
        end else begin
            file_buf.delete();
            put_random($urandom_range(1, 12));
        end
        ship_file();
    endtask

    // ---------------------------------------------------------------
    // Sequencing
    // ---------------------------------------------------------------
    task automatic settle();
        while (byte_feed.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic run_directed();
        // one-byte files at both byte extremes
        file_buf = '{8'h00};
        ship_file();
        file_buf = '{8'hFF};
        ship_file();
        // text at exactly the minimum size
        build_text(skel_word, spine_word, 6, 1'b0, 1'b1, sfs_pkg::TEXT_MIN_SIZE);
        ship_file();
        // fixed: good, zero length
        build_fixed(7, 1'b0, 20);
        ship_file();
        build_fixed(0, 1'b0, sfs_pkg::FIXED_MIN_SIZE);
        ship_file();
        // string: good, then version bytes cut off by the end of the file
        build_string(20, 6, 1'b0, 1'b0, sfs_pkg::STR_MIN_SIZE);
        ship_file();
        build_string(30, 12, 1'b0, 1'b0, sfs_pkg::STR_MIN_SIZE);
        ship_file();
    endtask

    initial begin
        int send_idle_by_phase[4];
        int recv_stall_by_phase[4];
        int phase_files;
        int phase_bytes;
        send_idle_by_phase  = '{0, 85, 0, 12};
        recv_stall_by_phase = '{0, 0, 85, 12};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_idle_by_phase[ph];
            recv_stall_pct = recv_stall_by_phase[ph];
            if (ph == 0) begin
                // hold the result side while tiny files pile up behind it
                hold_target = hold_target + LONG_HOLD;
                repeat (12) begin
                    file_buf.delete();
                    put_random($urandom_range(1, 2));
                    ship_file();
                end
            end
            phase_files = 0;
            phase_bytes = bytes_sent;
            while (phase_files < 3 || bytes_sent - phase_bytes < 25) begin
                ship_random_file();
                phase_files++;
            end
            // sender waits here for every verdict before the next phase
            settle();
        end

        repeat (8) @(negedge aclk);
        $display("covered %0d files, %0d bytes over four idle/stall mixes and a %0d-cycle hold",
                 files_sent, bytes_sent, LONG_HOLD);
        $display("verdicts: none %0d, text %0d, fixed %0d, string %0d, mismatches %0d",
                 fmt_tally[0], fmt_tally[1], fmt_tally[2], fmt_tally[3], mismatches);
        if (mismatches == 0) begin
            $display("skeleton_file_format_sniffer verification clean");
        end else begin
            $display("skeleton_file_format_sniffer verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/sfs_pkg.sv
src/sfs_text_check.sv
src/sfs_bin_check.sv
src/skeleton_file_format_sniffer.sv
dv/skeleton_file_format_sniffer_tb.sv
